// ----- hw/rtl/hcmp_pkg.sv -----
// ----------------------------------------------------------------------------
// Handover control message parser package
// Shared types and codes for the parser front end, word queue and emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package hcmp_pkg;

    localparam logic [7:0] STYLE_BYTE   = 8'd3;
    localparam logic [7:0] ACT_HANDOVER = 8'd1;
    localparam logic [7:0] ACT_COND     = 8'd2;
    localparam logic [7:0] ACT_DUAL     = 8'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        PH_STYLE,
        PH_ACTION,
        PH_ID_LEN,
        PH_ID_BYTES,
        PH_CELL_ID,
        PH_HO_TYPE,
        PH_HAS_SEC,
        PH_RECONF,
        PH_COUNT,
        PH_TRIG_LEN,
        PH_TRIG_BYTE,
        PH_HAS_TERM,
        PH_CAUSE,
        PH_DONE
    } t_phase;

    typedef enum logic [3:0] {
        K_ACTION      = 4'd0,
        K_ID_LEN      = 4'd1,
        K_ID_BYTE     = 4'd2,
        K_CELL_ID     = 4'd3,
        K_HO_TYPE     = 4'd4,
        K_HAS_SEC     = 4'd5,
        K_RECONF_ID   = 4'd6,
        K_CAND_COUNT  = 4'd7,
        K_TRIG_LEN    = 4'd8,
        K_TRIG_BYTE   = 4'd9,
        K_HAS_TERM    = 4'd10,
        K_CAUSE       = 4'd11,
        K_STATUS      = 4'd12
    } t_kind;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_BAD_STYLE = 2'd2,
        ST_UNK_ACT   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ROLE_PRIMARY   = 2'd0,
        ROLE_SECONDARY = 2'd1,
        ROLE_CANDIDATE = 2'd2
    } t_role;

    // One queue entry: the optional field and optional status caused by one word.
    typedef struct packed {
        logic        has_field;
        t_kind       kind;
        logic [63:0] value;
        t_role       role;
        logic [31:0] index;
        logic        has_status;
        t_status     status;
    } t_rec;

endpackage

`default_nettype wire

// ----- hw/rtl/hcmp_front.sv -----
// ----------------------------------------------------------------------------
// Handover control message parser front end
// Holds the parse state, classifies each input word and builds a queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module hcmp_front
    import hcmp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_message_end,
    output logic            o_push,
    output t_rec            o_rec
);

    t_phase      r_phase,   n_phase;
    logic [2:0]  r_fbc,     n_fbc;
    logic [63:0] r_acc,     n_acc;
    logic [31:0] r_payrem,  n_payrem;
    logic [31:0] r_candrem, n_candrem;
    logic [31:0] r_candcnt, n_candcnt;
    logic [1:0]  r_action,  n_action;
    t_role       r_role,    n_role;
    logic [1:0]  r_err,     n_err;
    logic        r_done,    n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_STYLE;
            r_fbc     <= '0;
            r_acc     <= '0;
            r_payrem  <= '0;
            r_candrem <= '0;
            r_candcnt <= '0;
            r_action  <= '0;
            r_role    <= ROLE_PRIMARY;
            r_err     <= '0;
            r_done    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_fbc     <= n_fbc;
            r_acc     <= n_acc;
            r_payrem  <= n_payrem;
            r_candrem <= n_candrem;
            r_candcnt <= n_candcnt;
            r_action  <= n_action;
            r_role    <= n_role;
            r_err     <= n_err;
            r_done    <= n_done;
        end
    end

    logic [63:0] acc_sh;
    logic [2:0]  fbc_inc;
    logic        shift_done;
    logic [31:0] candrem_dec;
    logic [31:0] payrem_dec;
    t_status     st;

    always_comb begin
        acc_sh = r_acc;
        acc_sh[{r_fbc, 3'b000} +: 8] = r_acc[{r_fbc, 3'b000} +: 8] | i_data_byte;
        fbc_inc     = r_fbc + 3'd1;
        candrem_dec = r_candrem - 32'd1;
        payrem_dec  = r_payrem - 32'd1;
        shift_done  = 1'b0;
        st          = ST_ACCEPTED;

        n_phase   = r_phase;
        n_fbc     = r_fbc;
        n_acc     = r_acc;
        n_payrem  = r_payrem;
        n_candrem = r_candrem;
        n_candcnt = r_candcnt;
        n_action  = r_action;
        n_role    = r_role;
        n_err     = r_err;
        n_done    = r_done;

        o_push           = 1'b0;
        o_rec.has_field  = 1'b0;
        o_rec.kind       = K_ACTION;
        o_rec.value      = {56'd0, i_data_byte};
        o_rec.role       = r_role;
        o_rec.index      = r_candcnt;
        o_rec.has_status = 1'b0;
        o_rec.status     = ST_ACCEPTED;

        case (r_phase)
            PH_ID_LEN:                shift_done = (r_fbc >= 3'd1);
            PH_RECONF, PH_COUNT,
            PH_TRIG_LEN:              shift_done = (r_fbc >= 3'd3);
            PH_CELL_ID:               shift_done = (r_fbc == 3'd7);
            default:                  shift_done = 1'b0;
        endcase

        if (i_accept && r_err == 2'd0 && !r_done) begin
            // Multi-byte fields gather little-endian until their last byte.
            if (r_phase == PH_ID_LEN || r_phase == PH_RECONF || r_phase == PH_COUNT ||
                r_phase == PH_TRIG_LEN || r_phase == PH_CELL_ID) begin
                if (shift_done) begin
                    n_acc       = '0;
                    n_fbc       = '0;
                    o_rec.value = acc_sh;
                end else begin
                    n_acc = acc_sh;
                    n_fbc = fbc_inc;
                end
            end

            case (r_phase)
                PH_STYLE: begin
                    if (i_data_byte != STYLE_BYTE) n_err = ST_BAD_STYLE;
                    else n_phase = PH_ACTION;
                end
                PH_ACTION: begin
                    o_rec.has_field = 1'b1;
                    o_rec.kind      = K_ACTION;
                    if (i_data_byte == ACT_HANDOVER || i_data_byte == ACT_DUAL) begin
                        n_action = i_data_byte[1:0];
                        n_role   = ROLE_PRIMARY;
                        n_phase  = PH_ID_LEN;
                    end else if (i_data_byte == ACT_COND) begin
                        n_action = i_data_byte[1:0];
                        n_phase  = PH_RECONF;
                    end else begin
                        n_err = ST_UNK_ACT;
                    end
                end
                PH_ID_LEN: begin
                    if (shift_done) begin
                        o_rec.has_field = 1'b1;
                        o_rec.kind      = K_ID_LEN;
                        n_payrem        = {16'd0, acc_sh[15:0]};
                        n_phase = (acc_sh[15:0] != 16'd0) ? PH_ID_BYTES : PH_CELL_ID;
                    end
                end
                PH_ID_BYTES: begin
                    o_rec.has_field = 1'b1;
                    o_rec.kind      = K_ID_BYTE;
                    n_payrem        = payrem_dec;
                    if (payrem_dec == 32'd0) n_phase = PH_CELL_ID;
                end
                PH_CELL_ID: begin
                    if (shift_done) begin
                        o_rec.has_field = 1'b1;
                        o_rec.kind      = K_CELL_ID;
                        if (r_action == ACT_HANDOVER[1:0]) begin
                            if (r_role == ROLE_PRIMARY) begin
                                n_phase = PH_HO_TYPE;
                            end else begin
                                n_done  = 1'b1;
                                n_phase = PH_DONE;
                            end
                        end else if (r_action == ACT_COND[1:0]) begin
                            n_phase = PH_TRIG_LEN;
                        end else begin
                            n_phase = PH_HAS_TERM;
                        end
                    end
                end
                PH_HO_TYPE: begin
                    o_rec.has_field = 1'b1;
                    o_rec.kind      = K_HO_TYPE;
                    n_phase         = PH_HAS_SEC;
                end
                PH_HAS_SEC: begin
                    o_rec.has_field = 1'b1;
                    o_rec.kind      = K_HAS_SEC;
                    if (i_data_byte != 8'd0) begin
                        n_role  = ROLE_SECONDARY;
                        n_phase = PH_ID_LEN;
                    end else begin
                        n_done  = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
                PH_RECONF: begin
                    if (shift_done) begin
                        o_rec.has_field = 1'b1;
                        o_rec.kind      = K_RECONF_ID;
                        n_phase         = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    if (shift_done) begin
                        o_rec.has_field = 1'b1;
                        o_rec.kind      = K_CAND_COUNT;
                        n_candrem       = acc_sh[31:0];
                        n_candcnt       = '0;
                        if (acc_sh[31:0] == 32'd0) begin
                            n_done  = 1'b1;
                            n_phase = PH_DONE;
                        end else begin
                            n_role  = ROLE_CANDIDATE;
                            n_phase = PH_ID_LEN;
                        end
                    end
                end
                PH_TRIG_LEN, PH_TRIG_BYTE: begin
                    if (r_phase == PH_TRIG_BYTE || shift_done) begin
                        o_rec.has_field = 1'b1;
                        o_rec.kind = (r_phase == PH_TRIG_BYTE) ? K_TRIG_BYTE : K_TRIG_LEN;
                        n_payrem   = (r_phase == PH_TRIG_BYTE) ? payrem_dec : acc_sh[31:0];
                        if (r_phase == PH_TRIG_LEN && acc_sh[31:0] != 32'd0) begin
                            n_phase = PH_TRIG_BYTE;
                        end else if (r_phase == PH_TRIG_LEN || payrem_dec == 32'd0) begin
                            // End of this candidate's section.
                            n_candrem = candrem_dec;
                            if (candrem_dec == 32'd0) begin
                                n_done  = 1'b1;
                                n_phase = PH_DONE;
                            end else begin
                                n_candcnt = r_candcnt + 32'd1;
                                n_phase   = PH_ID_LEN;
                            end
                        end
                    end
                end
                PH_HAS_TERM: begin
                    o_rec.has_field = 1'b1;
                    o_rec.kind      = K_HAS_TERM;
                    if (i_data_byte != 8'd0) begin
                        n_phase = PH_CAUSE;
                    end else begin
                        n_done  = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
                PH_CAUSE: begin
                    o_rec.has_field = 1'b1;
                    o_rec.kind      = K_CAUSE;
                    n_done          = 1'b1;
                    n_phase         = PH_DONE;
                end
                default: begin
                end
            endcase
        end

        if (n_err != 2'd0) st = t_status'(n_err);
        else if (n_done)   st = ST_ACCEPTED;
        else               st = ST_TRUNCATED;

        if (i_accept && i_message_end) begin
            o_rec.has_status = 1'b1;
            o_rec.status     = st;
            n_phase   = PH_STYLE;
            n_fbc     = '0;
            n_acc     = '0;
            n_payrem  = '0;
            n_candrem = '0;
            n_candcnt = '0;
            n_action  = '0;
            n_role    = ROLE_PRIMARY;
            n_err     = '0;
            n_done    = 1'b0;
        end

        o_push = i_accept && (o_rec.has_field || o_rec.has_status);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hcmp_queue.sv -----
// ----------------------------------------------------------------------------
// Handover control message parser entry queue
// Small first-in first-out buffer between the parser and the result emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module hcmp_queue
    import hcmp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_rec i_rec,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_rec      o_head
);

    t_rec                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wp, n_wp;
    logic [QUEUE_AW-1:0]  r_rp, n_rp;
    logic [QUEUE_AW:0]    r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (QUEUE_AW+1)'(i_push) - (QUEUE_AW+1)'(i_pop);
    end

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

endmodule

`default_nettype wire

// ----- hw/rtl/hcmp_back.sv -----
// ----------------------------------------------------------------------------
// Handover control message parser result emitter
// Unpacks each queue entry into one or two result words on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module hcmp_back
    import hcmp_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_empty,
    input  wire t_rec         i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [3:0]        o_field_kind,
    output logic [63:0]       o_field_value,
    output logic [1:0]        o_cell_role,
    output logic [31:0]       o_candidate_index,
    output logic [1:0]        o_status,
    output logic              o_last_result
);

    t_rec r_rec;
    logic r_have, n_have;
    logic r_sel,  n_sel;    // 0 shows the field, 1 shows the status
    logic finish;

    always_comb begin
        finish = r_have && i_ready && (r_sel || !r_rec.has_status);
        o_pop  = !i_empty && (!r_have || finish);
        n_have = r_have;
        n_sel  = r_sel;
        if (r_have && i_ready && !r_sel && r_rec.has_status) begin
            n_sel = 1'b1;
        end
        if (finish) begin
            n_have = 1'b0;
        end
        if (o_pop) begin
            n_have = 1'b1;
            n_sel  = !i_head.has_field;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_sel  <= 1'b0;
        end else begin
            r_have <= n_have;
            r_sel  <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_head;
        end
    end

    always_comb begin
        o_valid = r_have;
        if (r_sel) begin
            o_field_kind      = K_STATUS;
            o_field_value     = {62'd0, r_rec.status};
            o_cell_role       = ROLE_PRIMARY;
            o_candidate_index = '0;
            o_status          = r_rec.status;
            o_last_result     = 1'b1;
        end else begin
            o_field_kind      = r_rec.kind;
            o_field_value     = r_rec.value;
            o_cell_role       = r_rec.role;
            o_candidate_index = r_rec.index;
            o_status          = ST_ACCEPTED;
            o_last_result     = !r_rec.has_status;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/handover_control_message_parser_unit.sv -----
// ----------------------------------------------------------------------------
// Handover control message parser unit
// Parses a byte stream of little-endian handover control messages into
// tagged field words and one status word per message.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake           Payload
//  -------  ---------  ------------------  --------------------------------------
//  input    in         i_valid / o_ready   i_data_byte, i_message_end
//  output   out        o_valid / i_ready   o_field_kind, o_field_value,
//                                          o_cell_role, o_candidate_index,
//                                          o_status, o_last_result
//
// One input word is parsed in the cycle it is accepted; the parser can take a
// word every cycle while the queue has room. Each word yields at most two
// result words, which the emitter hands out one per cycle while i_ready is
// high, so throughput is limited by the output channel: one result word per
// cycle. A word's entry goes through a four-entry queue, then the emitter
// register; o_ready drops only when that queue is full. Synchronous active-low
// reset returns the parser to expecting a style byte with the queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module handover_control_message_parser_unit
    import hcmp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_message_end,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_field_kind,
    output logic [63:0]      o_field_value,
    output logic [1:0]       o_cell_role,
    output logic [31:0]      o_candidate_index,
    output logic [1:0]       o_status,
    output logic             o_last_result
);

    logic accept;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_rec rec;
    t_rec head;

    // A word is taken whenever the queue has room for its entry.
    assign o_ready = !full;
    assign accept  = i_valid && o_ready;

    hcmp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_message_end (i_message_end),
        .o_push        (push),
        .o_rec         (rec)
    );

    hcmp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    hcmp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (empty),
        .i_head            (head),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_field_kind      (o_field_kind),
        .o_field_value     (o_field_value),
        .o_cell_role       (o_cell_role),
        .o_candidate_index (o_candidate_index),
        .o_status          (o_status),
        .o_last_result     (o_last_result)
    );

endmodule

`default_nettype wire
